[rtl/apf_pkg.sv]
// ----------------------------------------------------------------------------
// apf_pkg
// Types, coefficient tables and constants for the altitude pressure fit.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int FRAC_BITS = 44;
  localparam int HORNER_STAGES = 5;
  localparam int POW2_STAGES = 30;
  localparam logic signed [55:0] HORNER_LIMIT = 56'sd1 <<< 54;
  localparam logic signed [27:0] LOG2E_Q26 = 28'sd96817625;
  localparam logic [42:0] PRESSURE_MAX = {43{1'b1}};
  localparam logic [9:0] SCALE_1000 = 10'd1000;

  localparam logic [15:0] BAND_EDGE [0:5] = '{16'd2816, 16'd4608, 16'd7168,
                                             16'd12800, 16'd21248, 16'd23040};

  typedef struct packed {
    logic                valid;
    logic [15:0]         z;
    logic [2:0]          band;
    logic signed [55:0]  acc;
  } hrn_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         band;
    logic               hi;
    logic               lo;
    logic [31:0]        f;
    logic signed [7:0]  s;
    logic [30:0]        m;
  } pw_t;

  function automatic logic signed [63:0] to_q44(input longint mant, input int dexp);
    longint unsigned d;
    longint unsigned a;
    longint unsigned q;
    longint unsigned r;
    d = 64'd1;
    for (int i = 0; i < dexp && i < 18; i++) d = d * 64'd10;
    a = (mant < 0) ? longint'(-mant) : longint'(mant);
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & 64'd1);
      q = q << 1;
      if (r >= d) begin
        q = q | 64'd1;
        r = r - d;
      end
    end
    for (int i = 0; i < FRAC_BITS + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        q = q | 64'd1;
        r = r - d;
      end
    end
    q = (q + 64'd1) >> 1;
    return (mant < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned x_in);
    longint unsigned x;
    longint unsigned res;
    longint unsigned b;
    x = x_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [30:0] pow2_factor(input int idx);
    longint unsigned t;
    t = isqrt64(64'd2 << 60);
    for (int j = 1; j < idx; j++) t = isqrt64(t << 30);
    return t[30:0];
  endfunction

  localparam logic signed [63:0] COEF [0:6][0:5] = '{
    '{to_q44(168716, 7), to_q44(-114252, 6), to_q44(-136123, 8),
      to_q44(736241, 10), to_q44(-108003, 10), to_q44(330464, 12)},
    '{to_q44(-799108, 7), to_q44(-810464, 7), to_q44(-555224, 8),
      to_q44(31117, 8), to_q44(-166878, 10), to_q44(3832, 10)},
    '{to_q44(984143, 6), to_q44(-269769, 6), to_q44(852275, 8),
      to_q44(-396203, 9), to_q44(101465, 10), to_q44(-102643, 12)},
    '{to_q44(218198, 5), to_q44(-411497, 6), to_q44(133665, 7),
      to_q44(-359519, 9), to_q44(510097, 11), to_q44(-289056, 13)},
    '{to_q44(76338, 5), to_q44(-258298, 6), to_q44(376139, 8),
      to_q44(-420887, 10), to_q44(1602, 10), to_q44(-192509, 15)},
    '{to_q44(-11279, 3), to_q44(31982, 5), to_q44(-58093, 7),
      to_q44(22331, 9), to_q44(0, 0), to_q44(0, 0)},
    '{to_q44(-109914, 3), to_q44(47143, 4), to_q44(-82123, 6),
      to_q44(6622, 7), to_q44(-25593, 10), to_q44(384825, 14)}
  };

  localparam logic [30:0] POW2_T [0:29] = '{
    pow2_factor(1), pow2_factor(2), pow2_factor(3), pow2_factor(4),
    pow2_factor(5), pow2_factor(6), pow2_factor(7), pow2_factor(8),
    pow2_factor(9), pow2_factor(10), pow2_factor(11), pow2_factor(12),
    pow2_factor(13), pow2_factor(14), pow2_factor(15), pow2_factor(16),
    pow2_factor(17), pow2_factor(18), pow2_factor(19), pow2_factor(20),
    pow2_factor(21), pow2_factor(22), pow2_factor(23), pow2_factor(24),
    pow2_factor(25), pow2_factor(26), pow2_factor(27), pow2_factor(28),
    pow2_factor(29), pow2_factor(30)
  };

endpackage

[rtl/apf_horner_cell.sv]
// ----------------------------------------------------------------------------
// apf_horner_cell
// One Horner step: acc = clamp(acc * z + coef), two register stages.
// ----------------------------------------------------------------------------
module apf_horner_cell (
  input  logic                clk,
  input  logic                rst,
  input  apf_pkg::hrn_t       din,
  input  logic signed [63:0]  coef,
  output apf_pkg::hrn_t       dout
);
  import apf_pkg::*;

  logic               mid_valid;
  logic [15:0]        mid_z;
  logic [2:0]         mid_band;
  logic               mid_neg;
  logic [62:0]        mid_p;
  logic signed [63:0] mid_coef;

  logic [54:0]        mag;
  logic [70:0]        prod;
  logic signed [64:0] sum;
  logic signed [64:0] lim_hi;
  logic signed [64:0] lim_lo;

  assign mag    = din.acc[55] ? 55'(-din.acc) : din.acc[54:0];
  assign prod   = 71'(mag) * 71'(din.z);
  assign lim_hi = 65'(HORNER_LIMIT);
  assign lim_lo = -65'(HORNER_LIMIT);
  assign sum    = (mid_neg ? -$signed({2'b00, mid_p}) : $signed({2'b00, mid_p}))
                  + 65'(mid_coef);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid  <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      mid_valid  <= din.valid;
      dout.valid <= mid_valid;
    end
    mid_z    <= din.z;
    mid_band <= din.band;
    mid_neg  <= din.acc[55];
    mid_p    <= prod[70:8];
    mid_coef <= coef;
    dout.z    <= mid_z;
    dout.band <= mid_band;
    if (sum > lim_hi) dout.acc <= HORNER_LIMIT;
    else if (sum < lim_lo) dout.acc <= -HORNER_LIMIT;
    else dout.acc <= sum[55:0];
  end

endmodule

[rtl/apf_pow2_cell.sv]
// ----------------------------------------------------------------------------
// apf_pow2_cell
// One fraction bit of 2^f: multiply by the table factor when the bit is set.
// ----------------------------------------------------------------------------
module apf_pow2_cell (
  input  logic         clk,
  input  logic         rst,
  input  apf_pkg::pw_t din,
  input  logic [30:0]  t,
  input  logic         sel,
  output apf_pkg::pw_t dout
);
  import apf_pkg::*;

  logic [61:0] prod;

  assign prod = (62'(din.m) * 62'(t)) + (62'd1 << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.band <= din.band;
    dout.hi   <= din.hi;
    dout.lo   <= din.lo;
    dout.f    <= din.f;
    dout.s    <= din.s;
    dout.m    <= sel ? prod[60:30] : din.m;
  end

endmodule

[rtl/altitude_pressure_poly_fit.sv]
// ----------------------------------------------------------------------------
// altitude_pressure_poly_fit
// Altitude to pressure: band select, quintic Horner chain, exp by 2^n * 2^f.
// Throughput one request per cycle. Registered stages in order: input, the
// Horner chain of five two-stage cells, exp argument, the thirty-cell 2^f
// chain, scale and output. busy stays low; results cannot be stalled.
// Synchronous reset clears all valid flags; no request is in flight after it.
// ----------------------------------------------------------------------------
module altitude_pressure_poly_fit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] altitude_km,
  output logic        done,
  output logic [42:0] pressure_hpa,
  output logic [2:0]  band
);
  import apf_pkg::*;

  hrn_t h [0:HORNER_STAGES];
  pw_t  p [0:POW2_STAGES];

  logic [2:0]         in_band;
  logic               ea_valid;
  logic [2:0]         ea_band;
  logic               ea_hi;
  logic               ea_lo;
  logic signed [69:0] ea_y;
  logic signed [45:0] yfl;
  logic               v_valid;
  logic [2:0]         v_band;
  logic               v_hi;
  logic               v_lo;
  logic signed [7:0]  v_s;
  logic [40:0]        v;
  logic [44:0]        vsh;
  logic [5:0]         rsh;
  logic [41:0]        vrnd;

  assign busy = 1'b0;

  always_comb begin
    in_band = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (altitude_km > BAND_EDGE[i]) in_band = 3'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h[0].valid <= 1'b0;
    end else begin
      h[0].valid <= start;
    end
    h[0].z    <= altitude_km;
    h[0].band <= in_band;
    h[0].acc  <= COEF[in_band][5][55:0];
  end

  for (genvar k = 0; k < HORNER_STAGES; k++) begin : g_horner
    apf_horner_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (h[k]),
      .coef (COEF[h[k].band][HORNER_STAGES - 1 - k]),
      .dout (h[k + 1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ea_valid <= 1'b0;
    end else begin
      ea_valid <= h[HORNER_STAGES].valid;
    end
    ea_band <= h[HORNER_STAGES].band;
    ea_hi   <= h[HORNER_STAGES].acc > (56'sd1 <<< FRAC_BITS);
    ea_lo   <= h[HORNER_STAGES].acc < -(56'sd31 <<< FRAC_BITS);
    ea_y    <= 70'(h[HORNER_STAGES].acc >>> 14) * 70'(LOG2E_Q26);
  end

  assign yfl = 46'(ea_y >>> 24);

  always_ff @(posedge clk) begin
    if (rst) begin
      p[0].valid <= 1'b0;
    end else begin
      p[0].valid <= ea_valid;
    end
    p[0].band <= ea_band;
    p[0].hi   <= ea_hi;
    p[0].lo   <= ea_lo;
    p[0].f    <= yfl[31:0];
    p[0].s    <= 8'(yfl[45:32]) + 8'sd2;
    p[0].m    <= 31'd1 << 30;
  end

  for (genvar i = 0; i < POW2_STAGES; i++) begin : g_pow2
    apf_pow2_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (p[i]),
      .t    (POW2_T[i]),
      .sel  (p[i].f[31 - i]),
      .dout (p[i + 1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else begin
      v_valid <= p[POW2_STAGES].valid;
    end
    v_band <= p[POW2_STAGES].band;
    v_hi   <= p[POW2_STAGES].hi;
    v_lo   <= p[POW2_STAGES].lo;
    v_s    <= p[POW2_STAGES].s;
    v      <= 41'(p[POW2_STAGES].m) * 41'(SCALE_1000);
  end

  assign vsh  = 45'(v) << v_s[1:0];
  assign rsh  = 6'(-v_s);
  assign vrnd = (42'(v) + (42'd1 << (rsh - 6'd1))) >> rsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_valid;
    end
    band <= v_band;
    if (v_hi) begin
      pressure_hpa <= PRESSURE_MAX;
    end else if (v_lo) begin
      pressure_hpa <= '0;
    end else if (!v_s[7]) begin
      if (v_s > 8'sd3 || vsh > 45'(PRESSURE_MAX)) pressure_hpa <= PRESSURE_MAX;
      else pressure_hpa <= vsh[42:0];
    end else begin
      pressure_hpa <= 43'(vrnd);
    end
  end

endmodule
